>>> src/stack_alu_with_flags_top_assert.svh
// Assertion macros used by the stack ALU controller.
// Needs clk and arst_n visible in the including module.
`ifndef STACK_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define STACK_ALU_WITH_FLAGS_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SAF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never hold on a clock edge outside reset.
`define SAF_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

>>> src/saf_pkg.sv
// Package for the stack ALU: operation codes, conditions, errors, states.
// No dependencies.
package saf_pkg;
	localparam int unsigned StackDepthDefault = 64;

	typedef enum logic [4:0] {
		FN_PUSH = 5'd0, FN_POP = 5'd1, FN_ADD = 5'd2, FN_SUB = 5'd3,
		FN_INC = 5'd4, FN_DEC = 5'd5, FN_IMUL = 5'd6, FN_IDIV = 5'd7,
		FN_AND = 5'd8, FN_OR = 5'd9, FN_XOR = 5'd10, FN_NOT = 5'd11,
		FN_NEG = 5'd12, FN_SHL = 5'd13, FN_SHR = 5'd14, FN_SHRL = 5'd15,
		FN_CMP = 5'd16, FN_TEST = 5'd17
	} func_t;

	localparam logic [2:0] CND_ALWAYS = 3'd0;
	localparam logic [2:0] CND_ZERO = 3'd1;
	localparam logic [2:0] CND_NZERO = 3'd2;
	localparam logic [2:0] CND_GT = 3'd3;
	localparam logic [2:0] CND_GE = 3'd4;
	localparam logic [2:0] CND_LT = 3'd5;
	localparam logic [2:0] CND_LE = 3'd6;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_UNDER = 2'd1;
	localparam logic [1:0] ERR_OVER = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD_B, ST_RD_A, ST_EXEC, ST_MDWAIT, ST_OUT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;     // capture input transaction
		logic rd_top;   // read entry at count-1 into b
		logic rd_next;  // read entry at count-2 into a
		logic start_md; // start multiply/divide
		logic exec;     // compute and write back
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic need1;
		logic need2;
		logic under;
		logic over;
		logic md_op;
		logic md_done;
	} stat_t;
endpackage

>>> src/saf_if.sv
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
interface saf_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> src/saf_muldiv.sv
// Iterative 32-bit multiplier (low word) and truncating signed divider.
// Uses saf_pkg. One bit per cycle.
module saf_muldiv (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic is_div,
	input logic [31:0] a,
	input logic [31:0] b,
	output logic done,
	output logic [31:0] res
);
	import saf_pkg::*;
	logic busy_q;
	logic [5:0] cnt_q;
	logic div_q, neg_q, zero_q;
	logic [31:0] acc_q, opa_q, opb_q, rem_q;
	logic [32:0] trial;
	logic [31:0] ma, mb;

	assign ma = a[31] ? 32'(-a) : a;
	assign mb = b[31] ? 32'(-b) : b;
	assign trial = {rem_q, opa_q[31]} - {1'b0, opb_q};

	// Shift-add multiply or restoring divide, one bit a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			zero_q <= (b == 32'd0);
			neg_q <= a[31] ^ b[31];
			acc_q <= '0;
			rem_q <= '0;
			opa_q <= is_div ? ma : a;
			opb_q <= is_div ? mb : b;
		end else if (busy_q) begin
			if (div_q) begin
				if (!trial[32]) rem_q <= trial[31:0];
				else rem_q <= {rem_q[30:0], opa_q[31]};
				opa_q <= {opa_q[30:0], !trial[32]};
			end else begin
				if (opb_q[0]) acc_q <= acc_q + opa_q;
				opa_q <= {opa_q[30:0], 1'b0};
				opb_q <= {1'b0, opb_q[31:1]};
			end
		end
	end

	// Quotient sits in opa_q after the last divide step.
	always_comb begin
		if (!div_q) res = acc_q;
		else if (zero_q) res = '0;
		else res = neg_q ? 32'(-opa_q) : opa_q;
	end
endmodule

>>> src/saf_datapath.sv
// Datapath: operand stack memory, operand registers, ALU, flags, result register.
// Uses saf_pkg, saf_muldiv.
module saf_datapath #(
	parameter int unsigned STACK_DEPTH = saf_pkg::StackDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input saf_pkg::cmd_t cmd,
	output saf_pkg::stat_t stat,
	input logic [4:0] in_func,
	input logic [31:0] in_push_value,
	input logic [2:0] in_condition,
	output logic [31:0] top_value,
	output logic cond_taken,
	output logic zero_flag,
	output logic sign_flag,
	output logic [6:0] depth,
	output logic [1:0] error
);
	import saf_pkg::*;
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [31:0] mem [STACK_DEPTH];
	logic [CW-1:0] cnt_q;
	logic zf_q, sf_q;
	logic [4:0] func_q;
	logic [31:0] pv_q, a_q, b_q;
	logic [2:0] cond_q;
	logic [CW-1:0] rd_idx;
	logic [31:0] r;
	logic md_done;
	logic [31:0] md_res;
	logic taken;
	logic wr_en;
	logic [CW-1:0] wr_idx;
	logic [CW-1:0] cnt_nx;
	logic [32:0] diff;

	// Operation classification.
	always_comb begin
		stat.need1 = (func_q == FN_POP) || (func_q == FN_INC) || (func_q == FN_DEC)
			|| (func_q == FN_NOT) || (func_q == FN_NEG);
		stat.need2 = !stat.need1 && (func_q >= FN_ADD) && (func_q <= FN_CMP);
		stat.under = (stat.need1 && cnt_q < CW'(1)) || (stat.need2 && cnt_q < CW'(2));
		stat.over = (func_q == FN_PUSH) && (cnt_q >= CW'(STACK_DEPTH));
		stat.md_op = (func_q == FN_IMUL) || (func_q == FN_IDIV);
		stat.md_done = md_done;
	end

	// Memory read address: top for b, next for a.
	assign rd_idx = cmd.rd_next ? cnt_q - CW'(2) : cnt_q - CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			pv_q <= in_push_value;
			cond_q <= in_condition;
		end
		if (cmd.rd_top) b_q <= mem[rd_idx[AW-1:0]];
		if (cmd.rd_next) a_q <= mem[rd_idx[AW-1:0]];
		if (wr_en) mem[wr_idx[AW-1:0]] <= r;
	end

	saf_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .start(cmd.start_md),
		.is_div(func_q == FN_IDIV), .a(a_q), .b(b_q),
		.done(md_done), .res(md_res)
	);

	// Unary ops use b (the top entry) as operand.
	assign diff = {1'b0, a_q} - {1'b0, b_q};
	always_comb begin
		case (func_q)
			FN_PUSH: r = pv_q;
			FN_POP: r = b_q;
			FN_ADD: r = a_q + b_q;
			FN_SUB, FN_CMP: r = diff[31:0];
			FN_INC: r = b_q + 32'd1;
			FN_DEC: r = b_q - 32'd1;
			FN_IMUL, FN_IDIV: r = md_res;
			FN_AND: r = a_q & b_q;
			FN_OR: r = a_q | b_q;
			FN_XOR: r = a_q ^ b_q;
			FN_NOT: r = ~b_q;
			FN_NEG: r = 32'(-b_q);
			FN_SHL: r = a_q << b_q[4:0];
			FN_SHR: r = 32'($signed(a_q) >>> b_q[4:0]);
			FN_SHRL: r = a_q >> b_q[4:0];
			default: r = '0;
		endcase
	end

	// Condition evaluation from the current flags.
	always_comb begin
		case (cond_q)
			CND_ALWAYS: taken = 1'b1;
			CND_ZERO: taken = zf_q;
			CND_NZERO: taken = !zf_q;
			CND_GT: taken = !sf_q && !zf_q;
			CND_GE: taken = !sf_q;
			CND_LT: taken = sf_q;
			CND_LE: taken = sf_q || zf_q;
			default: taken = 1'b0;
		endcase
	end

	// Write back and new depth.
	always_comb begin
		wr_en = 1'b0;
		wr_idx = cnt_q;
		cnt_nx = cnt_q;
		if (cmd.exec && !stat.under && !stat.over) begin
			if (func_q == FN_PUSH) begin
				wr_en = 1'b1;
				cnt_nx = cnt_q + CW'(1);
			end else if (func_q == FN_POP) begin
				cnt_nx = cnt_q - CW'(1);
			end else if (stat.need1) begin
				wr_en = 1'b1;
				wr_idx = cnt_q - CW'(1);
			end else if (func_q == FN_CMP) begin
				cnt_nx = cnt_q - CW'(2);
			end else if (stat.need2) begin
				wr_en = 1'b1;
				wr_idx = cnt_q - CW'(2);
				cnt_nx = cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			zf_q <= 1'b0;
			sf_q <= 1'b0;
		end else if (cmd.exec) begin
			cnt_q <= cnt_nx;
			if (func_q == FN_CMP && !stat.under) begin
				zf_q <= (diff[31:0] == 32'd0);
				sf_q <= diff[31];
			end
		end
	end

	// Result register, loaded in the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			top_value <= (stat.under || stat.over || func_q == FN_CMP) ? 32'd0 : r;
			cond_taken <= (func_q == FN_TEST) && taken;
			error <= stat.under ? ERR_UNDER : (stat.over ? ERR_OVER : ERR_OK);
		end
	end
	assign zero_flag = zf_q;
	assign sign_flag = sf_q;
	assign depth = 7'(cnt_q);
endmodule

>>> src/saf_ctrl.sv
// Controller state machine sequencing reads, execute and output handshake.
// Uses saf_pkg and the assertion macro header.
`include "stack_alu_with_flags_top_assert.svh"
module saf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input saf_pkg::stat_t stat,
	output saf_pkg::cmd_t cmd
);
	import saf_pkg::*;
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_RD_B;
				end
			end
			ST_RD_B: begin
				if (!stat.under && (stat.need1 || stat.need2)) cmd.rd_top = 1'b1;
				state_nx = (stat.need2 && !stat.under) ? ST_RD_A : ST_EXEC;
			end
			ST_RD_A: begin
				cmd.rd_next = 1'b1;
				state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.md_op && !stat.under) begin
					cmd.start_md = 1'b1;
					state_nx = ST_MDWAIT;
				end else begin
					cmd.exec = 1'b1;
					state_nx = ST_OUT;
				end
			end
			ST_MDWAIT: begin
				if (stat.md_done) begin
					cmd.exec = 1'b1;
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	`SAF_NEVER(a_excl, in_ready && out_valid, "input and output open together")
	`SAF_ASSERT(a_exec_out, cmd.exec |=> out_valid, "execute not followed by result")
	`SAF_ASSERT(a_load_rd, cmd.load |=> (state_q == ST_RD_B), "load not followed by read")
endmodule

>>> src/stack_alu_with_flags_top.sv
// Top level of the stack ALU with zero and sign flags.
// Uses saf_pkg, saf_if, saf_ctrl, saf_datapath.
// Usage:
//   The in channel carries one operation per transaction (func, push_value,
//   condition); the out channel returns one result transaction per operation
//   with top_value, cond_taken, flags, depth and error.
//   Each operation passes through the controller states in order: a
//   registered read of the top entry, a registered read of the next entry
//   for binary operations, execute, for imul and idiv a wait on the
//   bit-serial multiply/divide unit, then the result transaction.
//   One operation is in flight at a time; a new one can be accepted in the
//   cycle after the previous result transaction completes.
//   Reset clears depth and the flags; stack contents stay undefined until
//   pushed.
//   If the receiver stalls, the result is held steady and no input is taken.
module stack_alu_with_flags_top #(
	parameter int unsigned STACK_DEPTH = saf_pkg::StackDepthDefault
) (
	input logic clk,
	input logic arst_n,
	saf_if.sink in_ch,
	saf_if.source out_ch
);
	import saf_pkg::*;
	cmd_t cmd;
	stat_t stat;

	saf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	saf_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_func(in_ch.payload.func), .in_push_value(in_ch.payload.push_value),
		.in_condition(in_ch.payload.condition),
		.top_value(out_ch.payload.top_value), .cond_taken(out_ch.payload.cond_taken),
		.zero_flag(out_ch.payload.zero_flag), .sign_flag(out_ch.payload.sign_flag),
		.depth(out_ch.payload.depth), .error(out_ch.payload.error)
	);
endmodule

>>> verif/saf_tb_pkg.sv
`timescale 1ns / 1ps
// Transaction types carried on the stack ALU channels in the testbench.
// Depends on saf_pkg for the operation codes.
package saf_tb_pkg;
	import saf_pkg::*;

	typedef struct packed {
		logic [4:0] func;
		logic signed [31:0] push_value;
		logic [2:0] condition;
	} op_item_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic cond_taken;
		logic zero_flag;
		logic sign_flag;
		logic [6:0] depth;
		logic [1:0] error;
	} result_item_t;
endpackage

>>> verif/saf_checker.sv
`timescale 1ns / 1ps
// Checker for the stack ALU: tracks stack and flags, predicts each result
// and compares it with the out channel. Depends on saf_pkg, saf_tb_pkg, saf_if.
module saf_checker #(
	parameter int unsigned STACK_DEPTH = saf_pkg::StackDepthDefault
) (
	input logic clk,
	input logic arst_n,
	saf_if in_ch,
	saf_if out_ch,
	output int failures,
	output int pending
);
	import saf_pkg::*;
	import saf_tb_pkg::*;

	logic [31:0] stack_mem [STACK_DEPTH];
	int unsigned stack_cnt;
	logic zf, sf;
	result_item_t expected_results[$];

	// Truncating signed divide, zero for a zero divisor.
	function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		if (b == 0)
			return 0;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic logic test_cond(logic [2:0] c);
		case (c)
			CND_ALWAYS: return 1'b1;
			CND_ZERO: return zf;
			CND_NZERO: return !zf;
			CND_GT: return !sf && !zf;
			CND_GE: return !sf;
			CND_LT: return sf;
			CND_LE: return sf || zf;
			default: return 1'b0;
		endcase
	endfunction

	// Applies one operation to the tracked state and returns its result.
	function automatic result_item_t execute_op(op_item_t op);
		result_item_t res;
		int unsigned need;
		logic [31:0] a, b, r;
		res = '0;
		need = 0;
		if (op.func inside {FN_POP, FN_INC, FN_DEC, FN_NOT, FN_NEG})
			need = 1;
		else if (op.func >= FN_ADD && op.func <= FN_CMP)
			need = 2;
		if (op.func == FN_PUSH) begin
			if (stack_cnt >= STACK_DEPTH) begin
				res.error = ERR_OVER;
			end else begin
				stack_mem[stack_cnt] = op.push_value;
				stack_cnt++;
				res.top_value = op.push_value;
			end
		end else if (op.func == FN_TEST) begin
			res.cond_taken = test_cond(op.condition);
		end else if (need != 0) begin
			if (stack_cnt < need) begin
				res.error = ERR_UNDER;
			end else if (need == 1) begin
				a = stack_mem[stack_cnt-1];
				case (op.func)
					FN_POP: r = a;
					FN_INC: r = a + 1;
					FN_DEC: r = a - 1;
					FN_NOT: r = ~a;
					default: r = -a;
				endcase
				if (op.func == FN_POP)
					stack_cnt--;
				else
					stack_mem[stack_cnt-1] = r;
				res.top_value = r;
			end else begin
				b = stack_mem[stack_cnt-1];
				a = stack_mem[stack_cnt-2];
				stack_cnt -= 2;
				if (op.func == FN_CMP) begin
					r = a - b;
					zf = (r == 0);
					sf = r[31];
				end else begin
					case (op.func)
						FN_ADD: r = a + b;
						FN_SUB: r = a - b;
						FN_IMUL: r = a * b;
						FN_IDIV: r = div_trunc(a, b);
						FN_AND: r = a & b;
						FN_OR: r = a | b;
						FN_XOR: r = a ^ b;
						FN_SHL: r = a << b[4:0];
						FN_SHR: r = $signed(a) >>> b[4:0];
						default: r = a >> b[4:0];
					endcase
					stack_mem[stack_cnt] = r;
					stack_cnt++;
					res.top_value = r;
				end
			end
		end
		res.zero_flag = zf;
		res.sign_flag = sf;
		res.depth = stack_cnt[6:0];
		return res;
	endfunction

	assign pending = expected_results.size();

	// Predict on each accepted operation, compare on each accepted result.
	always @(posedge clk or negedge arst_n) begin
		result_item_t exp_res, got;
		if (!arst_n) begin
			stack_cnt = 0;
			zf = 0;
			sf = 0;
			failures = 0;
			expected_results.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(execute_op(in_ch.payload));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				if (expected_results.size() == 0) begin
					$error("result transaction with no operation outstanding");
					failures++;
				end else begin
					exp_res = expected_results.pop_front();
					if (got.top_value !== exp_res.top_value) begin
						$error("top_value: expected %0d, got %0d",
							exp_res.top_value, got.top_value);
						failures++;
					end
					if (got.cond_taken !== exp_res.cond_taken) begin
						$error("cond_taken: expected %0b, got %0b",
							exp_res.cond_taken, got.cond_taken);
						failures++;
					end
					if (got.zero_flag !== exp_res.zero_flag) begin
						$error("zero_flag: expected %0b, got %0b",
							exp_res.zero_flag, got.zero_flag);
						failures++;
					end
					if (got.sign_flag !== exp_res.sign_flag) begin
						$error("sign_flag: expected %0b, got %0b",
							exp_res.sign_flag, got.sign_flag);
						failures++;
					end
					if (got.depth !== exp_res.depth) begin
						$error("depth: expected %0d, got %0d", exp_res.depth, got.depth);
						failures++;
					end
					if (got.error !== exp_res.error) begin
						$error("error: expected %0d, got %0d", exp_res.error, got.error);
						failures++;
					end
				end
			end
		end
	end
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the stack ALU testbench: clock, reset, operation stimulus and verdict.
// Depends on saf_pkg, saf_tb_pkg, saf_if, saf_checker and the block itself.
module testbench;
	import saf_pkg::*;
	import saf_tb_pkg::*;

	localparam int RandomOps = 1250;

	logic clk;
	logic arst_n;
	logic calm;
	int failures, pending;
	int ready_hold;
	int leftover;

	saf_if #(.payload_t(op_item_t)) in_ch ();
	saf_if #(.payload_t(result_item_t)) out_ch ();

	stack_alu_with_flags_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	saf_checker #(.STACK_DEPTH(StackDepthDefault)) checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Bound on the whole run.
	initial begin
		#4ms;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver stalls in random bursts, none once the run turns calm.
	initial begin
		out_ch.ready = 0;
		ready_hold = 0;
	end
	always @(posedge clk) begin
		if (calm) begin
			out_ch.ready <= 1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ch.ready <= 0;
			ready_hold <= $urandom_range(1, 19);
		end else begin
			out_ch.ready <= 1;
		end
	end

	// Issues one operation and waits until it is taken; valid stays high.
	task automatic send_op(logic [4:0] fn, logic [31:0] pv, logic [2:0] cnd);
		op_item_t op;
		op.func = fn;
		op.push_value = pv;
		op.condition = cnd;
		in_ch.valid <= 1;
		in_ch.payload <= op;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic pause_sender(int cycles);
		in_ch.valid <= 0;
		repeat (cycles) @(posedge clk);
	endtask

	// Mix of extremes, shift-sized and arbitrary values.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 0;
			4, 5: return $urandom_range(0, 40);
			6: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int fill_bias;
		int r;
		logic [4:0] fn;
		arst_n = 0;
		calm = 0;
		in_ch.valid = 0;
		in_ch.payload = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: underflow on empty, wraps, divide corners, shifts, flags.
		send_op(FN_POP, 0, 3'd0);
		send_op(FN_PUSH, 32'h7fff_ffff, 3'd0);
		send_op(FN_ADD, 0, 3'd0);
		send_op(FN_INC, 0, 3'd0);
		send_op(FN_PUSH, 32'hffff_ffff, 3'd0);
		send_op(FN_IDIV, 0, 3'd0);
		send_op(FN_PUSH, 0, 3'd0);
		send_op(FN_IDIV, 0, 3'd0);
		send_op(FN_PUSH, 32'h8000_0000, 3'd0);
		send_op(FN_PUSH, 33, 3'd0);
		send_op(FN_SHR, 0, 3'd0);
		send_op(FN_PUSH, 31, 3'd0);
		send_op(FN_SHRL, 0, 3'd0);
		send_op(FN_PUSH, 5, 3'd0);
		send_op(FN_CMP, 0, 3'd0);
		for (int c = 0; c < 8; c++)
			send_op(FN_TEST, 0, 3'(c));
		send_op(5'd31, 32'hffff_ffff, 3'd7);
		send_op(FN_PUSH, 0, 3'd0);
		send_op(FN_PUSH, 0, 3'd0);
		send_op(FN_CMP, 0, 3'd0);

		// Random: phases that fill or drain the stack with random content.
		fill_bias = 50;
		for (int i = 0; i < RandomOps; i++) begin
			if (i % 60 == 0)
				fill_bias = $urandom_range(20, 85);
			if (i == RandomOps - 150)
				calm = 1;
			if (i == 600) begin
				in_ch.valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (!calm && $urandom_range(0, 4) == 0)
				pause_sender($urandom_range(1, 19));
			r = $urandom_range(0, 99);
			if (r < fill_bias)
				fn = FN_PUSH;
			else if (r < 96)
				fn = 5'($urandom_range(FN_POP, FN_TEST));
			else
				fn = 5'($urandom_range(0, 31));
			send_op(fn, pick_value(), 3'($urandom_range(0, 7)));
		end
		in_ch.valid <= 0;

		// Drain outstanding results, then allow for trailing latency.
		leftover = 0;
		while (pending != 0 && leftover < 5000) begin
			@(posedge clk);
			leftover++;
		end
		repeat (60) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
